/* sv/pbu_pkg.sv */
// Shared types, codes and constants of the pixel blend unit.
// No dependencies; imported by every module of the block.
package pbu_pkg;

	// Blend mode codes; codes 10..15 are unused and pass the destination through
	typedef enum logic [3:0] {
		MODE_REPLACE = 4'd0,
		MODE_ADD     = 4'd1,
		MODE_ALPHA   = 4'd2,
		MODE_MULT    = 4'd3,
		MODE_OVERLAY = 4'd4,
		MODE_SCREEN  = 4'd5,
		MODE_GRAY    = 4'd6,
		MODE_LBURN   = 4'd7,
		MODE_TINT    = 4'd8,
		MODE_DESAT   = 4'd9
	} mode_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_RED   = 2'd1;
	localparam logic [1:0] REG_GREEN = 2'd2;
	localparam logic [1:0] REG_BLUE  = 2'd3;

	// Reset values of the channel offsets
	localparam logic [4:0] RED_OFS_RST   = 5'd16;
	localparam logic [4:0] GREEN_OFS_RST = 5'd8;
	localparam logic [4:0] BLUE_OFS_RST  = 5'd0;

	// Arithmetic constants
	localparam logic [7:0] CHAN_MAX = 8'hff;
	localparam logic [8:0] GRAY_MUL = 9'd341;
	localparam logic [7:0] LUMA_MUL = 8'd205;
	localparam logic [6:0] TINT_MUL = 7'h78;

	// One channel of an item after the first two stages
	typedef struct packed {
		logic [7:0]  d;
		logic [7:0]  s;
		logic [15:0] p;
	} chan_t;

	// Values shared by all three channel lanes
	typedef struct packed {
		logic signed [8:0] f;
		logic [7:0]        fs;
		logic              f_max;
		logic              fs_max;
		logic [7:0]        gray;
		logic [7:0]        luma;
		logic [7:0]        sgray;
	} shared_t;

	// Saturate a signed value to 0..255
	function automatic logic [7:0] clip8(input logic signed [11:0] v);
		logic [7:0] r;
		if (v < 12'sd0) begin
			r = 8'd0;
		end else if (v > 12'sd255) begin
			r = CHAN_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// Overlay of one channel; p is the product d * s
	function automatic logic [7:0] ov_mix(input logic [7:0] d, input logic [7:0] s,
		input logic [15:0] p);
		logic signed [11:0] t;
		logic [7:0]         r;
		t = signed'(12'({d, 1'b0}) + 12'({s, 1'b0})) - 12'sd255 - signed'(12'(p[15:7]));
		if (!d[7]) begin
			r = p[14:7];
		end else begin
			r = clip8(t);
		end
		return r;
	endfunction

endpackage

/* sv/pbu_front.sv */
// Front of the blend pipeline: channel extraction and first products.
// Depends on pbu_pkg for the channel and shared types.
module pbu_front (
	input  logic                   clk,
	input  logic [4:0]             red_offset,
	input  logic [4:0]             green_offset,
	input  logic [4:0]             blue_offset,
	input  logic [31:0]            dest_pixel,
	input  logic [31:0]            source_pixel,
	input  logic signed [8:0]      blend_factor,
	output pbu_pkg::chan_t         r_s2,
	output pbu_pkg::chan_t         g_s2,
	output pbu_pkg::chan_t         b_s2,
	output pbu_pkg::shared_t       sh_s2
);
	import pbu_pkg::*;

	logic [7:0]        dr_s1, dg_s1, db_s1;
	logic [7:0]        sr_s1, sg_s1, sb_s1;
	logic signed [8:0] f_s1;
	logic [7:0]        fs_s1;
	logic              fmax_s1;

	logic [9:0]  dsum, ssum;
	logic [11:0] lsum;
	logic [18:0] gray_prod, sgray_prod;
	logic [19:0] luma_prod;

	// Stage 1: pull the channel bytes out and saturate the factor
	always_ff @(posedge clk) begin
		dr_s1   <= 8'(dest_pixel >> red_offset);
		dg_s1   <= 8'(dest_pixel >> green_offset);
		db_s1   <= 8'(dest_pixel >> blue_offset);
		sr_s1   <= 8'(source_pixel >> red_offset);
		sg_s1   <= 8'(source_pixel >> green_offset);
		sb_s1   <= 8'(source_pixel >> blue_offset);
		f_s1    <= blend_factor;
		fs_s1   <= blend_factor[8] ? 8'd0 : blend_factor[7:0];
		fmax_s1 <= (blend_factor == 9'sd255);
	end

	// Channel sums scaled for gray level and luma
	always_comb begin
		dsum       = 10'(dr_s1) + 10'(dg_s1) + 10'(db_s1);
		ssum       = 10'(sr_s1) + 10'(sg_s1) + 10'(sb_s1);
		lsum       = 12'({dr_s1, 1'b0}) + 12'(dr_s1) + 12'({dg_s1, 2'b0})
			+ 12'({dg_s1, 1'b0}) + 12'(db_s1);
		gray_prod  = 19'(dsum) * 19'(GRAY_MUL);
		sgray_prod = 19'(ssum) * 19'(GRAY_MUL);
		luma_prod  = 20'(lsum) * 20'(LUMA_MUL);
	end

	// Stage 2: register channel products and the shared tone values
	always_ff @(posedge clk) begin
		r_s2.d <= dr_s1;
		r_s2.s <= sr_s1;
		r_s2.p <= 16'(dr_s1) * 16'(sr_s1);
		g_s2.d <= dg_s1;
		g_s2.s <= sg_s1;
		g_s2.p <= 16'(dg_s1) * 16'(sg_s1);
		b_s2.d <= db_s1;
		b_s2.s <= sb_s1;
		b_s2.p <= 16'(db_s1) * 16'(sb_s1);
		sh_s2.f      <= f_s1;
		sh_s2.fs     <= fs_s1;
		sh_s2.f_max  <= fmax_s1;
		sh_s2.fs_max <= (fs_s1 == CHAN_MAX);
		sh_s2.gray   <= gray_prod[17:10];
		sh_s2.sgray  <= sgray_prod[17:10];
		sh_s2.luma   <= luma_prod[18:11];
	end

endmodule

/* sv/pbu_lane.sv */
// One color channel lane: mix target, mix product and final channel value.
// Depends on pbu_pkg for the mode codes, types, clip8 and ov_mix.
module pbu_lane (
	input  logic             clk,
	input  pbu_pkg::mode_t   mode,
	input  logic             tint_en,
	input  pbu_pkg::chan_t   chan,
	input  pbu_pkg::shared_t sh,
	output logic [7:0]       c_s5
);
	import pbu_pkg::*;

	logic [14:0]       tint_prod;
	logic [8:0]        ds_sum;
	logic [7:0]        burn, ovx, x;
	logic signed [9:0] ma, mb;

	logic signed [9:0] ma_s3, mb_s3;
	logic [7:0]        d_s3, s_s3, x_s3, phi_s3, gray_s3, fs_s3;
	logic              fsmax_s3, fmax_s3;

	logic signed [19:0] prod_s4;
	logic [7:0]         d_s4, s_s4, x_s4, phi_s4, gray_s4, fs_s4;
	logic               fsmax_s4, fmax_s4;

	logic signed [11:0] dv, shv, mix, sum_ds;
	logic [7:0]         c;

	// Mix target of the channel
	always_comb begin
		tint_prod = 15'(CHAN_MAX - sh.sgray) * 15'(TINT_MUL);
		ds_sum    = 9'(chan.d) + 9'(chan.s);
		burn      = (ds_sum < 9'd255) ? 8'd0 : 8'(ds_sum - 9'd255);
		ovx       = ov_mix(chan.d, chan.s, chan.p);
		case (mode)
			MODE_ALPHA:   x = chan.s;
			MODE_OVERLAY: x = ovx;
			MODE_LBURN:   x = burn;
			MODE_TINT:    x = tint_en ? 8'(tint_prod[14:8]) : 8'd0;
			default:      x = 8'd0;
		endcase
	end

	// Pick the operands of the lane multiplier
	always_comb begin
		case (mode)
			MODE_ADD: begin
				ma = signed'({2'b00, chan.s});
				mb = {sh.f[8], sh.f};
			end
			MODE_ALPHA, MODE_OVERLAY, MODE_LBURN, MODE_TINT: begin
				ma = signed'({2'b00, x}) - signed'({2'b00, chan.d});
				mb = signed'({2'b00, sh.fs});
			end
			MODE_SCREEN: begin
				ma = signed'({2'b00, CHAN_MAX - chan.s});
				mb = signed'({2'b00, CHAN_MAX - chan.d});
			end
			MODE_GRAY: begin
				ma = signed'({2'b00, sh.gray});
				mb = signed'({2'b00, sh.fs});
			end
			MODE_DESAT: begin
				ma = signed'({2'b00, sh.luma}) - signed'({2'b00, chan.d});
				mb = signed'({2'b00, sh.fs});
			end
			default: begin
				ma = 10'sd0;
				mb = 10'sd0;
			end
		endcase
	end

	// Stage 3: hold operands and the values the final step needs
	always_ff @(posedge clk) begin
		ma_s3    <= ma;
		mb_s3    <= mb;
		d_s3     <= chan.d;
		s_s3     <= chan.s;
		x_s3     <= x;
		phi_s3   <= chan.p[15:8];
		gray_s3  <= sh.gray;
		fs_s3    <= sh.fs;
		fsmax_s3 <= sh.fs_max;
		fmax_s3  <= sh.f_max;
	end

	// Stage 4: the mix product
	always_ff @(posedge clk) begin
		prod_s4  <= ma_s3 * mb_s3;
		d_s4     <= d_s3;
		s_s4     <= s_s3;
		x_s4     <= x_s3;
		phi_s4   <= phi_s3;
		gray_s4  <= gray_s3;
		fs_s4    <= fs_s3;
		fsmax_s4 <= fsmax_s3;
		fmax_s4  <= fmax_s3;
	end

	// Finish the channel per mode; the product shifts down with floor rounding
	always_comb begin
		dv     = signed'({4'b0000, d_s4});
		shv    = prod_s4[19:8];
		mix    = dv + shv;
		sum_ds = dv + signed'({4'b0000, s_s4});
		case (mode)
			MODE_ADD:     c = fmax_s4 ? clip8(sum_ds) : clip8(mix);
			MODE_ALPHA, MODE_OVERLAY, MODE_LBURN, MODE_TINT:
				c = fsmax_s4 ? x_s4 : mix[7:0];
			MODE_MULT:    c = phi_s4;
			MODE_SCREEN:  c = CHAN_MAX - prod_s4[15:8];
			MODE_GRAY:    c = ov_mix(gray_s4, fs_s4, prod_s4[15:0]);
			MODE_DESAT:   c = clip8(mix);
			default:      c = 8'd0;
		endcase
	end

	// Stage 5: channel result
	always_ff @(posedge clk) begin
		c_s5 <= c;
	end

endmodule

/* sv/pixel_blend_unit_top.sv */
// Top level of the pixel blend unit: configuration registers, valid chain,
// output packing. Depends on pbu_pkg, pbu_front and pbu_lane.
//
// Usage:
//   Input channel: drive dest_pixel, source_pixel and blend_factor with start
//   high; the item is taken at that clock edge when busy is low. busy is
//   never raised, so one item can be taken at every clock edge.
//   Result channel: done is high for exactly one cycle with result_pixel
//   valid in that cycle. The receiver cannot stall; every result must be
//   taken in the cycle it appears.
//   Pipeline: an item taken at a clock edge passes six register stages
//   (extract, products, mix operands, mix product, channel finish, pack)
//   before its result shows. Throughput: one item per clock.
//   Configuration: wr_en, wr_index and wr_data write blend_mode (0), and the
//   red, green and blue offsets (1..3) at the clock edge; write only while
//   no item is in flight.
//   Reset: arst_n low clears the valid chain and loads mode replace with
//   offsets 16, 8 and 0. Results in flight are dropped.
module pixel_blend_unit_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [31:0]       dest_pixel,
	input  logic [31:0]       source_pixel,
	input  logic signed [8:0] blend_factor,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [4:0]        wr_data,
	output logic              done,
	output logic [31:0]       result_pixel
);
	import pbu_pkg::*;

	typedef struct packed {
		logic [31:0] sw;
		logic [31:0] dw;
		logic        fs_max;
	} pass_t;

	mode_t      mode_q;
	logic [4:0] red_offset_q, green_offset_q, blue_offset_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	pass_t pass_s1, pass_s2, pass_s3, pass_s4, pass_s5;

	chan_t      r_s2, g_s2, b_s2;
	shared_t    sh_s2;
	logic [7:0] r_s5, g_s5, b_s5;
	logic [31:0] packed_word, result_next;
	logic [31:0] result_pixel_s6;

	assign busy = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_REPLACE;
			red_offset_q   <= RED_OFS_RST;
			green_offset_q <= GREEN_OFS_RST;
			blue_offset_q  <= BLUE_OFS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE:  mode_q         <= mode_t'(wr_data[3:0]);
				REG_RED:   red_offset_q   <= wr_data;
				REG_GREEN: green_offset_q <= wr_data;
				REG_BLUE:  blue_offset_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Carry the pass-through words alongside the lanes
	always_ff @(posedge clk) begin
		pass_s1.sw     <= source_pixel;
		pass_s1.dw     <= dest_pixel;
		pass_s1.fs_max <= (blend_factor == 9'sd255);
		pass_s2        <= pass_s1;
		pass_s3        <= pass_s2;
		pass_s4        <= pass_s3;
		pass_s5        <= pass_s4;
	end

	pbu_front u_front (
		.clk          (clk),
		.red_offset   (red_offset_q),
		.green_offset (green_offset_q),
		.blue_offset  (blue_offset_q),
		.dest_pixel   (dest_pixel),
		.source_pixel (source_pixel),
		.blend_factor (blend_factor),
		.r_s2         (r_s2),
		.g_s2         (g_s2),
		.b_s2         (b_s2),
		.sh_s2        (sh_s2)
	);

	pbu_lane u_lane_r (
		.clk     (clk),
		.mode    (mode_q),
		.tint_en (1'b0),
		.chan    (r_s2),
		.sh      (sh_s2),
		.c_s5    (r_s5)
	);

	pbu_lane u_lane_g (
		.clk     (clk),
		.mode    (mode_q),
		.tint_en (1'b1),
		.chan    (g_s2),
		.sh      (sh_s2),
		.c_s5    (g_s5)
	);

	pbu_lane u_lane_b (
		.clk     (clk),
		.mode    (mode_q),
		.tint_en (1'b0),
		.chan    (b_s2),
		.sh      (sh_s2),
		.c_s5    (b_s5)
	);

	// Pack the channels at their offsets, or pass a whole word through
	always_comb begin
		packed_word = (32'(r_s5) << red_offset_q) | (32'(g_s5) << green_offset_q)
			| (32'(b_s5) << blue_offset_q);
		case (mode_q)
			MODE_REPLACE: result_next = pass_s5.sw;
			MODE_ALPHA:   result_next = pass_s5.fs_max ? pass_s5.sw : packed_word;
			MODE_ADD, MODE_MULT, MODE_OVERLAY, MODE_SCREEN, MODE_GRAY, MODE_LBURN,
			MODE_TINT, MODE_DESAT:
				result_next = packed_word;
			default:      result_next = pass_s5.dw;
		endcase
	end

	// Stage 6: output register
	always_ff @(posedge clk) begin
		result_pixel_s6 <= result_next;
	end

	assign result_pixel = result_pixel_s6;
	assign done         = valid_s6;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted item did not produce a result after six cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result strobe without an item accepted six cycles before");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for pixel_blend_unit_top: a scoreboard class predicts
// every blended pixel from the register settings; plain tasks drive items and writes.
// Depends on pbu_pkg and pixel_blend_unit_top.
`timescale 1ns / 100ps

module tb_top;
	import pbu_pkg::*;

	// Code of an unused blend mode; the block passes the destination through
	localparam logic [3:0] MODE_UNUSED = 4'd15;

	// Predicts blended pixels and checks them in order of arrival
	class blend_scoreboard;
		logic [3:0]  mode;
		logic [4:0]  red_ofs;
		logic [4:0]  green_ofs;
		logic [4:0]  blue_ofs;
		logic [31:0] expected_pixels[$];
		int          errors;

		function new();
			mode      = MODE_REPLACE;
			red_ofs   = RED_OFS_RST;
			green_ofs = GREEN_OFS_RST;
			blue_ofs  = BLUE_OFS_RST;
			errors    = 0;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [4:0] val);
			case (idx)
				REG_MODE:  mode      = val[3:0];
				REG_RED:   red_ofs   = val;
				REG_GREEN: green_ofs = val;
				REG_BLUE:  blue_ofs  = val;
				default: ;
			endcase
		endfunction

		// Byte at a bit offset; bits above 31 read as zero
		function int channel(input logic [31:0] w, input logic [4:0] ofs);
			return int'((w >> ofs) & 32'hff);
		endfunction

		function logic [31:0] pack(input int r, input int g, input int b);
			logic [63:0] acc;
			acc = (64'(r & 255) << red_ofs) | (64'(g & 255) << green_ofs)
				| (64'(b & 255) << blue_ofs);
			return acc[31:0];
		endfunction

		function int clip(input int v);
			return (v < 0) ? 0 : ((v > 255) ? 255 : v);
		endfunction

		// Linear mix from d toward s; full factor lands exactly on s
		function int mix(input int d, input int s, input int f);
			if (f == 255)
				return s;
			return ((((s - d) * f) >>> 8) + d) & 255;
		endfunction

		function int overlay(input int d, input int s);
			if (d < 128)
				return ((d * s) >> 7) & 255;
			return clip(2 * (d + s) - 255 - ((d * s) >> 7));
		endfunction

		function logic [31:0] blend_pixel(input logic [31:0] dw, input logic [31:0] sw,
			input logic signed [8:0] factor);
			int f, fs, dr, dg, db, sr, sg, sb, r, g, b, t;
			f  = factor;
			fs = (f < 0) ? 0 : f;
			dr = channel(dw, red_ofs);
			dg = channel(dw, green_ofs);
			db = channel(dw, blue_ofs);
			sr = channel(sw, red_ofs);
			sg = channel(sw, green_ofs);
			sb = channel(sw, blue_ofs);
			case (mode_t'(mode))
				MODE_REPLACE: return sw;
				MODE_ADD: begin
					// full factor adds unmodulated; otherwise the signed factor scales
					if (f == 255)
						return pack(clip(dr + sr), clip(dg + sg), clip(db + sb));
					return pack(clip(dr + ((sr * f) >>> 8)), clip(dg + ((sg * f) >>> 8)),
						clip(db + ((sb * f) >>> 8)));
				end
				MODE_ALPHA: begin
					if (fs == 255)
						return sw;
					return pack(mix(dr, sr, fs), mix(dg, sg, fs), mix(db, sb, fs));
				end
				MODE_MULT: return pack((dr * sr) >> 8, (dg * sg) >> 8, (db * sb) >> 8);
				MODE_OVERLAY:
					return pack(mix(dr, overlay(dr, sr), fs), mix(dg, overlay(dg, sg), fs),
						mix(db, overlay(db, sb), fs));
				MODE_SCREEN:
					return pack(255 - (((255 - sr) * (255 - dr)) >> 8),
						255 - (((255 - sg) * (255 - dg)) >> 8),
						255 - (((255 - sb) * (255 - db)) >> 8));
				MODE_GRAY: begin
					t = overlay(((dr + dg + db) * int'(GRAY_MUL)) >> 10, fs);
					return pack(t, t, t);
				end
				MODE_LBURN: begin
					r = (dr + sr < 255) ? 0 : dr + sr - 255;
					g = (dg + sg < 255) ? 0 : dg + sg - 255;
					b = (db + sb < 255) ? 0 : db + sb - 255;
					return pack(mix(dr, r, fs), mix(dg, g, fs), mix(db, b, fs));
				end
				MODE_TINT: begin
					t = ((255 - (((sr + sg + sb) * int'(GRAY_MUL)) >> 10))
						* int'(TINT_MUL)) >> 8;
					return pack(mix(dr, 0, fs), mix(dg, t, fs), mix(db, 0, fs));
				end
				MODE_DESAT: begin
					t = ((3 * dr + 6 * dg + db) * int'(LUMA_MUL)) >> 11;
					return pack(clip(dr + ((fs * (t - dr)) >>> 8)),
						clip(dg + ((fs * (t - dg)) >>> 8)),
						clip(db + ((fs * (t - db)) >>> 8)));
				end
				default: return dw;
			endcase
		endfunction

		function void note_item(input logic [31:0] dw, input logic [31:0] sw,
			input logic signed [8:0] factor);
			expected_pixels.push_back(blend_pixel(dw, sw, factor));
		endfunction

		function void check_result(input logic [31:0] got);
			logic [31:0] want;
			if (expected_pixels.size() == 0) begin
				$error("result_pixel with no item pending: actual %h", got);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got !== want) begin
				$error("result_pixel mismatch: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [31:0]       dest_pixel;
	logic [31:0]       source_pixel;
	logic signed [8:0] blend_factor;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [4:0]        wr_data;
	logic              done;
	logic [31:0]       result_pixel;

	blend_scoreboard sb = new();
	logic [4:0] dir_modes[11];
	bit         burst;

	pixel_blend_unit_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.dest_pixel   (dest_pixel),
		.source_pixel (source_pixel),
		.blend_factor (blend_factor),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.done         (done),
		.result_pixel (result_pixel)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each result in the cycle it is strobed
	always @(posedge clk) begin
		if (done)
			sb.check_result(result_pixel);
	end

	// Hard stop for a hung run
	initial begin
		#3ms;
		$display("tb_top failed");
		$finish;
	end

	// Present one item after a gap and hold it until taken
	task automatic drive_item(input logic [31:0] dw, input logic [31:0] sw,
		input logic signed [8:0] factor, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start        <= 1'b1;
		dest_pixel   <= dw;
		source_pixel <= sw;
		blend_factor <= factor;
		do @(posedge clk); while (busy);
		sb.note_item(dw, sw, factor);
	endtask

	// Wait for every expected pixel, bounded
	task automatic wait_drain();
		int n;
		n = 0;
		while (sb.pending() > 0 && n < 1000) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		sb.set_reg(idx, val);
	endtask

	// Stop items, drain the pipeline, then rewrite every register
	task automatic configure(input logic [4:0] mode_val, input logic [4:0] red_val,
		input logic [4:0] green_val, input logic [4:0] blue_val);
		@(negedge clk);
		start <= 1'b0;
		wait_drain();
		write_reg(REG_MODE, mode_val);
		write_reg(REG_RED, red_val);
		write_reg(REG_GREEN, green_val);
		write_reg(REG_BLUE, blue_val);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Mostly defined modes, sometimes an unused code with the top data bit set or not
	function automatic logic [4:0] pick_mode();
		if ($urandom_range(0, 5) == 0)
			return 5'($urandom_range(10, 31));
		return 5'($urandom_range(0, 9));
	endfunction

	// Byte-aligned, arbitrary, or past the top of the word
	function automatic logic [4:0] pick_offset();
		case ($urandom_range(0, 2))
			0: return 5'($urandom_range(0, 3) * 8);
			1: return 5'($urandom_range(0, 31));
			default: return 5'($urandom_range(25, 31));
		endcase
	endfunction

	function automatic logic signed [8:0] pick_factor();
		logic signed [8:0] corners[8];
		corners = '{9'h100, -9'sd1, 9'sd0, 9'sd1, 9'sd127, 9'sd128, 9'sd254, 9'sd255};
		case ($urandom_range(0, 3))
			0: return 9'($urandom_range(0, 511));
			1: return corners[$urandom_range(0, 7)];
			default: return 9'($urandom_range(0, 255));
		endcase
	endfunction

	// Fully random word, or bytes near the clip and overlay boundaries
	function automatic logic [31:0] pick_word();
		logic [7:0]  edges[6];
		logic [31:0] w;
		edges = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
		if ($urandom_range(0, 1) == 0)
			return $urandom;
		for (int i = 0; i < 4; i++)
			w[i*8 +: 8] = edges[$urandom_range(0, 5)];
		return w;
	endfunction

	// Reset, directed items, random phases, final check
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		dest_pixel   = '0;
		source_pixel = '0;
		blend_factor = '0;
		wr_en        = 1'b0;
		wr_index     = '0;
		wr_data      = '0;
		dir_modes = '{MODE_REPLACE, MODE_ADD, MODE_ALPHA, MODE_MULT, MODE_OVERLAY,
			MODE_SCREEN, MODE_GRAY, MODE_LBURN, MODE_TINT, MODE_DESAT, MODE_UNUSED};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every mode at full factor and at the most negative factor
		foreach (dir_modes[i]) begin
			configure(dir_modes[i], RED_OFS_RST, GREEN_OFS_RST, BLUE_OFS_RST);
			drive_item(32'hffffffff, 32'h807f01fe, 9'sd255, 0);
			drive_item(32'h00807f01, 32'hffffffff, 9'h100, 1);
		end

		// red and green past the top of the word, all three channels overlapping
		configure(MODE_ADD, 5'd31, 5'd31, 5'd24);
		drive_item(32'hffffffff, 32'h80000001, 9'sd128, 0);

		for (int p = 0; p < 14; p++) begin
			if ($urandom_range(0, 2) == 0)
				configure(pick_mode(), RED_OFS_RST, GREEN_OFS_RST, BLUE_OFS_RST);
			else
				configure(pick_mode(), pick_offset(), pick_offset(), pick_offset());
			burst = ($urandom_range(0, 2) == 0);
			repeat (45)
				drive_item(pick_word(), pick_word(), pick_factor(),
					burst ? 0 : $urandom_range(0, 18));
		end

		@(negedge clk);
		start <= 1'b0;
		wait_drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			$error("result_pixel: %0d expected items never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
